### hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue: storage sizes,
// the heap entry layout, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Storage geometry.
  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  // Child indexes reach twice the depth, so they need two more bits than an index.
  localparam int unsigned CHILD_W    = IDX_W + 2;

  // Item field widths.
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned PRI_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LIM_W  = 7;

  // Configuration register file.
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;
  localparam logic [CNT_W-1:0] HEAP_DEPTH_CNT = CNT_W'(HEAP_DEPTH);
  localparam logic [LIM_W-1:0] HEAP_LIMIT_RST = LIM_W'(64);

  // Register index of the heap limit.
  localparam logic REG_HEAP_LIMIT = 1'b0;

  // One heap entry as it sits in the store.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [PRI_W-1:0] pri;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // Which candidate the compare unit picked.
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_C0   = 2'd1,
    SEL_C1   = 2'd2
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_RD,
    ST_EX_LOAD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_OUT
  } state_e;

endpackage

### hdl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM with one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  output logic [WIDTH-1:0]         rdata0_o,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

### hdl/mhpq_sel.sv
// ----------------------------------------------------------------------------
// mhpq_sel
// Shared priority compare unit. Starting from the held priority it takes the
// first candidate if it is strictly larger, then the second candidate if it
// is valid and strictly larger than whatever won so far.
// ----------------------------------------------------------------------------
module mhpq_sel
  import mhpq_pkg::*;
(
  input  logic [PRI_W-1:0] hold_pri_i,
  input  logic [PRI_W-1:0] c0_pri_i,
  input  logic             c1_valid_i,
  input  logic [PRI_W-1:0] c1_pri_i,
  output sel_e             sel_o
);

  logic [PRI_W-1:0] best_pri;
  logic             take_c0;

  // Two strict compares in a chain; ties keep the earlier choice.
  always_comb begin
    take_c0  = (c0_pri_i > hold_pri_i);
    best_pri = take_c0 ? c0_pri_i : hold_pri_i;
    if (c1_valid_i && (c1_pri_i > best_pri)) begin
      sel_o = SEL_C1;
    end else if (take_c0) begin
      sel_o = SEL_C0;
    end else begin
      sel_o = SEL_HOLD;
    end
  end

endmodule

### hdl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of symbol and priority pairs with an APB limit register.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready while it works on it.
// An insert walks up the heap and an extract walks down; each level has a
// read state, which reads the parent or the two children from the entry
// RAM, and a compare state, which compares in the shared compare unit and
// writes one entry back. An item that overflows or underflows goes from the
// accepting state straight to the output state. An insert that climbs all
// six levels of a 64-entry heap passes through the accepting state, the
// levels, a step that settles the entry at the root and a step that loads
// the output register. An extract that sinks to a leaf passes through the
// accepting state, a read and a load state that fetch the root and the last
// entry, up to five levels, a step that settles and a step that loads the
// output register. The result sits in that register until it is taken, and
// the block stays busy while a new result waits for that register to free
// up. Inserts into a full heap return overflow; extracts from an empty heap
// return symbol 0 with underflow. The limit register sits at byte address 0.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [SYM_W-1:0]    symbol_in_i,
  input  logic [PRI_W-1:0]    priority_in_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SYM_W-1:0]    symbol_out_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [CNT_W-1:0]    entries_o
);

  state_e             state_q, state_d;
  logic [LIM_W-1:0]   heap_limit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   k_q, k_d;
  entry_t             mov_q, mov_d;
  logic [SYM_W-1:0]   res_sym_q, res_sym_d;
  status_e            res_stat_q, res_stat_d;

  logic               out_valid_q, out_valid_d;
  logic [SYM_W-1:0]   out_sym_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_load;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr0, ram_raddr1;
  entry_t             rd0, rd1;

  logic               in_accept;
  logic               reg_write;
  logic [CNT_W-1:0]   limit_eff;
  logic               heap_full;
  logic [IDX_W-1:0]   parent_idx;
  logic [CHILD_W-1:0] left_idx, right_idx;
  logic               left_ok, right_ok;
  logic [PRI_W-1:0]   sel_hold_pri, sel_c0_pri;
  sel_e               sel;

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == REG_HEAP_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HEAP_LIMIT_RST;
    end else if (reg_write) begin
      heap_limit_q <= pwdata[LIM_W-1:0];
    end
  end

  // Reads of an address past the register return zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEAP_LIMIT) begin
      prdata = APB_DW'(heap_limit_q);
    end
  end

  // --------------------------------------------------------------------------
  // Index arithmetic and limit check.
  // --------------------------------------------------------------------------
  assign limit_eff  = (CNT_W'(heap_limit_q) > HEAP_DEPTH_CNT) ? HEAP_DEPTH_CNT
                                                              : CNT_W'(heap_limit_q);
  assign heap_full  = (count_q >= limit_eff);
  assign parent_idx = (k_q - IDX_W'(1)) >> 1;
  assign left_idx   = {1'b0, k_q, 1'b1};
  assign right_idx  = CHILD_W'({1'b0, k_q, 1'b0}) + CHILD_W'(2);
  assign left_ok    = (left_idx < CHILD_W'(count_q));
  assign right_ok   = (right_idx < CHILD_W'(count_q));

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Shared compare unit: on the way up the parent is held and the moving
  // entry is the candidate; on the way down the moving entry is held.
  // --------------------------------------------------------------------------
  assign sel_hold_pri = (state_q == ST_UP_CMP) ? rd0.pri : mov_q.pri;
  assign sel_c0_pri   = (state_q == ST_UP_CMP) ? mov_q.pri : rd0.pri;

  mhpq_sel u_sel (
    .hold_pri_i (sel_hold_pri),
    .c0_pri_i   (sel_c0_pri),
    .c1_valid_i ((state_q == ST_DN_CMP) && right_ok),
    .c1_pri_i   (rd1.pri),
    .sel_o      (sel)
  );

  mhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .rdata0_o (rd0),
    .raddr1_i (ram_raddr1),
    .rdata1_o (rd1)
  );

  // --------------------------------------------------------------------------
  // Next-state logic of the sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_e'(operation_i) == OP_INSERT) begin
            state_d = heap_full ? ST_OUT : ST_UP_RD;
          end else begin
            state_d = (count_q == '0) ? ST_OUT : ST_EX_RD;
          end
        end
      end
      ST_UP_RD:   state_d = (k_q == '0) ? ST_OUT : ST_UP_CMP;
      ST_UP_CMP:  state_d = (sel == SEL_C0) ? ST_UP_RD : ST_OUT;
      ST_EX_RD:   state_d = ST_EX_LOAD;
      ST_EX_LOAD: state_d = (count_q == CNT_W'(1)) ? ST_OUT : ST_DN_RD;
      ST_DN_RD:   state_d = left_ok ? ST_DN_CMP : ST_OUT;
      ST_DN_CMP:  state_d = (sel == SEL_HOLD) ? ST_OUT : ST_DN_RD;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control of the sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    count_d    = count_q;
    k_d        = k_q;
    mov_d      = mov_q;
    res_sym_d  = res_sym_q;
    res_stat_d = res_stat_q;
    ram_we     = 1'b0;
    ram_waddr  = k_q;
    ram_wdata  = mov_q;
    ram_raddr0 = '0;
    ram_raddr1 = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_sym_d  = '0;
          res_stat_d = STAT_DONE;
          if (op_e'(operation_i) == OP_INSERT) begin
            if (heap_full) begin
              res_stat_d = STAT_OVERFLOW;
            end else begin
              k_d       = count_q[IDX_W-1:0];
              mov_d.sym = symbol_in_i;
              mov_d.pri = priority_in_i;
              count_d   = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            res_stat_d = STAT_UNDERFLOW;
          end
        end
      end
      // Read the parent, or settle the new entry at the root.
      ST_UP_RD: begin
        ram_raddr0 = parent_idx;
        if (k_q == '0) begin
          ram_we = 1'b1;
        end
      end
      // Move the parent down, or settle the new entry here.
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (sel == SEL_C0) begin
          ram_wdata = rd0;
          k_d       = parent_idx;
        end
      end
      // Fetch the root and the last entry together.
      ST_EX_RD: begin
        ram_raddr0 = '0;
        ram_raddr1 = IDX_W'(count_q - CNT_W'(1));
      end
      ST_EX_LOAD: begin
        res_sym_d = rd0.sym;
        count_d   = count_q - CNT_W'(1);
        mov_d     = rd1;
        k_d       = '0;
      end
      // Read both children, or settle the moving entry at a leaf.
      ST_DN_RD: begin
        ram_raddr0 = left_idx[IDX_W-1:0];
        ram_raddr1 = right_idx[IDX_W-1:0];
        if (!left_ok) begin
          ram_we = 1'b1;
        end
      end
      // Move the larger child up, or settle the moving entry here.
      ST_DN_CMP: begin
        ram_we = 1'b1;
        case (sel)
          SEL_C0: begin
            ram_wdata = rd0;
            k_d       = left_idx[IDX_W-1:0];
          end
          SEL_C1: begin
            ram_wdata = rd1;
            k_d       = right_idx[IDX_W-1:0];
          end
          default: begin
            ram_wdata = mov_q;
          end
        endcase
      end
      ST_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    mov_q      <= mov_d;
    res_sym_q  <= res_sym_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_sym_q  <= res_sym_q;
      out_stat_q <= res_stat_q;
      out_cnt_q  <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = out_sym_q;
  assign status_o     = out_stat_q;
  assign entries_o    = out_cnt_q;

endmodule

### tb/sv/max_heap_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking bench for the max-heap priority queue. A queue of pending
// operations feeds a valid/ready driver. Each accepted item is applied to a
// shadow heap, and the reply that this gives is queued. A monitor compares
// every reply that the block hands out against the oldest queued one. The
// heap limit is rewritten between phases: a directed opening, then random
// fill and drain runs under several limits.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned GAP_PCT     = 22;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic [PRI_W-1:0] pri;
  } heap_op_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    status_e          status;
    logic [CNT_W-1:0] entries;
  } heap_reply_t;

  // Clock, reset and block ports.
  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  heap_op_t          offer = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SYM_W-1:0]  symbol_out;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entries;

  // Operations waiting to be offered, and replies the heap still owes.
  heap_op_t    op_backlog[$];
  heap_reply_t heap_replies[$];

  // Shadow heap and limit.
  logic [SYM_W-1:0] shadow_sym [HEAP_DEPTH];
  logic [PRI_W-1:0] shadow_pri [HEAP_DEPTH];
  int unsigned      shadow_count = 0;
  logic [LIM_W-1:0] shadow_limit = HEAP_LIMIT_RST;

  bit          gaps_on = 1'b1;
  int unsigned bad_replies = 0;
  int unsigned replies_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  max_heap_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (offer.op),
    .symbol_in_i   (offer.sym),
    .priority_in_i (offer.pri),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .symbol_out_o  (symbol_out),
    .status_o      (status),
    .entries_o     (entries)
  );

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("max_heap_priority_queue test failed");
      $finish;
    end
  end

  // Exchange two heap slots in the shadow copy.
  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [SYM_W-1:0] s;
    logic [PRI_W-1:0] p;
    s = shadow_sym[a];
    p = shadow_pri[a];
    shadow_sym[a] = shadow_sym[b];
    shadow_pri[a] = shadow_pri[b];
    shadow_sym[b] = s;
    shadow_pri[b] = p;
  endfunction

  // Apply one operation to the shadow heap and return the reply it gives.
  function automatic heap_reply_t heap_apply(input heap_op_t item);
    heap_reply_t reply;
    int unsigned cap;
    int unsigned k;
    int unsigned best;
    int unsigned l;
    int unsigned r;
    bit          moving;
    cap = (shadow_limit > HEAP_DEPTH) ? HEAP_DEPTH : shadow_limit;
    reply.sym = '0;
    reply.status = STAT_DONE;
    if (item.op == OP_INSERT) begin
      if (shadow_count >= cap) begin
        reply.status = STAT_OVERFLOW;
      end else begin
        k = shadow_count;
        shadow_sym[k] = item.sym;
        shadow_pri[k] = item.pri;
        shadow_count = k + 1;
        // Climb while the parent is strictly lower.
        while (k != 0 && shadow_pri[(k - 1) / 2] < shadow_pri[k]) begin
          swap_slots(k, (k - 1) / 2);
          k = (k - 1) / 2;
        end
      end
    end else if (shadow_count == 0) begin
      reply.status = STAT_UNDERFLOW;
    end else begin
      reply.sym = shadow_sym[0];
      shadow_count = shadow_count - 1;
      if (shadow_count != 0) begin
        shadow_sym[0] = shadow_sym[shadow_count];
        shadow_pri[0] = shadow_pri[shadow_count];
        // Sink toward the strictly larger child; the right one wins only if
        // it beats the left one.
        k = 0;
        moving = 1'b1;
        while (moving) begin
          best = k;
          l = 2 * k + 1;
          r = 2 * k + 2;
          if (l < shadow_count && shadow_pri[l] > shadow_pri[best]) best = l;
          if (r < shadow_count && shadow_pri[r] > shadow_pri[best]) best = r;
          if (best == k) begin
            moving = 1'b0;
          end else begin
            swap_slots(k, best);
            k = best;
          end
        end
      end
    end
    reply.entries = CNT_W'(shadow_count);
    return reply;
  endfunction

  // Input driver: account for the accepted item, then offer the next one.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        heap_replies.push_back(heap_apply(offer));
      end
      if (!in_valid || in_ready) begin
        if (op_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
          offer <= op_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each reply, and stall the receiver now and then.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (heap_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10) begin
            $display("unrequested item: sym %0h status %0d entries %0d",
                     symbol_out, status, entries);
          end
        end else begin
          if (heap_replies[0].sym !== symbol_out || heap_replies[0].status !== status ||
              heap_replies[0].entries !== entries) begin
            bad_replies++;
            if (bad_replies <= 10) begin
              $display("item mismatch: want sym %0h status %0d entries %0d,",
                       heap_replies[0].sym, heap_replies[0].status,
                       heap_replies[0].entries);
              $display("               got sym %0h status %0d entries %0d",
                       symbol_out, status, entries);
            end
          end
          void'(heap_replies.pop_front());
        end
        replies_seen++;
        // Long hold-offs let the block fill up and stall its input.
        if (replies_seen == 300 || replies_seen == 900) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !gaps_on || $urandom_range(99) >= GAP_PCT;
      end
    end
  end

  task automatic push_item(input op_e op, input logic [SYM_W-1:0] sym,
                           input logic [PRI_W-1:0] pri);
    heap_op_t item;
    item.op = op;
    item.sym = sym;
    item.pri = pri;
    op_backlog.push_back(item);
  endtask

  // Wait until nothing is offered or owed; checked away from the clock edge.
  task automatic wait_drained();
    @(negedge clk_i);
    while (op_backlog.size() != 0 || in_valid || heap_replies.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Register write of the heap limit, with a setup phase and an access phase.
  task automatic write_limit(input int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_HEAP_LIMIT, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_limit = LIM_W'(value);
    @(negedge clk_i);
  endtask

  // Random fill and drain runs; the level tracks the heap as generated.
  task automatic queue_random_phase(input int unsigned limit, input int unsigned count);
    int unsigned cap;
    int unsigned level;
    int unsigned pick;
    bit          filling;
    bit          is_insert;
    logic [PRI_W-1:0] pri;
    cap = (limit > HEAP_DEPTH) ? HEAP_DEPTH : limit;
    level = shadow_count;
    filling = 1'b1;
    repeat (count) begin
      if (filling && level >= cap && $urandom_range(2) == 0) filling = 1'b0;
      else if (!filling && level == 0 && $urandom_range(1) == 0) filling = 1'b1;
      else if ($urandom_range(49) == 0) filling = !filling;
      is_insert = filling ? ($urandom_range(99) < 88) : ($urandom_range(99) < 12);
      // Narrow ranges give ties, the extremes come up now and then.
      pick = $urandom_range(7);
      if (pick < 2) pri = PRI_W'($urandom_range(3));
      else if (pick == 2) pri = $urandom_range(1) ? '1 : '0;
      else pri = PRI_W'($urandom);
      push_item(is_insert ? OP_INSERT : OP_EXTRACT, SYM_W'($urandom), pri);
      if (is_insert && level < cap) level++;
      else if (!is_insert && level != 0) level--;
    end
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned phase_limits [10];
    int unsigned idx;
    phase_limits = '{64, 127, 1, 64, 100, 2, 64, 17, 64, 127};
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // Small limit: underflow, ties with the root, overflow, single entry.
    write_limit(3);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_INSERT, 8'hFF, 16'hFFFF);
    push_item(OP_INSERT, 8'h00, 16'h0000);
    push_item(OP_INSERT, 8'hA5, 16'hFFFF);
    push_item(OP_INSERT, 8'h5A, 16'h0001);
    push_item(OP_EXTRACT, 8'hFF, 16'hFFFF);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    wait_drained();

    // Zero limit: every insert overflows.
    write_limit(0);
    push_item(OP_INSERT, 8'h12, 16'h1234);
    push_item(OP_INSERT, 8'hFF, 16'hFFFF);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    wait_drained();

    // Limit lowered below the count: inserts overflow, extracts still work.
    write_limit(64);
    push_item(OP_INSERT, 8'h10, 16'd10);
    push_item(OP_INSERT, 8'h20, 16'd30);
    push_item(OP_INSERT, 8'h30, 16'd20);
    push_item(OP_INSERT, 8'h40, 16'd30);
    wait_drained();
    write_limit(2);
    push_item(OP_INSERT, 8'h50, 16'd50);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_INSERT, 8'h60, 16'd60);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_INSERT, 8'h70, 16'd5);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    push_item(OP_EXTRACT, 8'h00, 16'h0000);
    wait_drained();

    // Random phases under a range of limits, one of them without gaps.
    for (idx = 0; idx < 10; idx++) begin
      write_limit(phase_limits[idx]);
      gaps_on = (idx != 6);
      queue_random_phase(phase_limits[idx], (phase_limits[idx] >= 64) ? 150 : 60);
      wait_drained();
    end
    gaps_on = 1'b1;

    repeat (40) @(posedge clk_i);
    if (bad_replies == 0) begin
      $display("max_heap_priority_queue test passed");
    end else begin
      $display("max_heap_priority_queue test failed");
    end
    $finish;
  end

endmodule
